/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at an edge, post must hold at the next edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// pre holds at an edge, post must hold at the same edge
`define ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

/* src/fip_pkg.sv */
// types and constants of the face index line parser
package fip_pkg;

  localparam int unsigned IndexBits = 16;
  localparam int unsigned OutBits   = 16;
  localparam int unsigned WideBits  = (IndexBits > OutBits) ? IndexBits : OutBits;

  localparam int unsigned Corners   = 3;
  localparam int unsigned Fields    = 3;
  localparam int unsigned StoreSize = Corners * Fields;
  localparam int unsigned SlotBits  = $clog2(StoreSize);

  localparam int unsigned CountBits = 3;
  localparam int unsigned FposBits  = 2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QcntBits   = $clog2(QueueDepth + 1);
  localparam int unsigned QptrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef logic [IndexBits-1:0] index_t;
  typedef logic [OutBits-1:0]   out_idx_t;

  typedef enum logic [1:0] {
    CLS_BLANK,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } cmd_side_t;

  typedef struct packed {
    out_idx_t [StoreSize-1:0] idx;
    logic                     count_error;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

endpackage

/* src/fip_front.sv */
// front end: byte classifier and command queue
module fip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        text_byte_i,
  input  logic              last_of_line_i,
  input  logic              cmd_pop_i,
  output fip_pkg::cmd_side_t cmd_side_o
);

  fip_pkg::cmd_t                         cmd_in;
  fip_pkg::cmd_t [fip_pkg::QueueDepth-1:0] slot_q;
  logic [fip_pkg::QcntBits-1:0]          count_q, count_d;
  logic [fip_pkg::QptrBits-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic                                  do_push, do_pop, empty;

  // classify the byte
  always_comb begin
    cmd_in.last  = last_of_line_i;
    cmd_in.digit = text_byte_i[3:0];
    if (text_byte_i == fip_pkg::CharSpace ||
        (text_byte_i >= fip_pkg::CharTab && text_byte_i <= fip_pkg::CharCr)) begin
      cmd_in.cls = fip_pkg::CLS_BLANK;
    end else if (text_byte_i >= fip_pkg::CharZero && text_byte_i <= fip_pkg::CharNine) begin
      cmd_in.cls = fip_pkg::CLS_DIGIT;
    end else begin
      cmd_in.cls = fip_pkg::CLS_OTHER;
    end
  end

  assign full_o  = (count_q == fip_pkg::QcntBits'(fip_pkg::QueueDepth));
  assign empty   = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && !empty;

  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == fip_pkg::QptrBits'(fip_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fip_pkg::QptrBits'(fip_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_side_o.empty = empty;
  assign cmd_side_o.cmd   = slot_q[rd_ptr_q];

endmodule

/* src/fip_exec.sv */
// back end: number accumulation, index store and line-end result
module fip_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fip_pkg::cmd_side_t cmd_side_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output fip_pkg::res_push_t res_push_o
);

  logic [fip_pkg::CountBits-1:0] tok_q, tok_d, tok_a, tok_b;
  logic [fip_pkg::FposBits-1:0]  fpos_q, fpos_d, fpos_a;
  fip_pkg::index_t               acc_q, acc_d, acc_a;
  logic                          in_tok_q, in_tok_d, in_tok_a;
  fip_pkg::index_t [fip_pkg::StoreSize-1:0] store_q, store_d, store_mid;

  logic                          go;
  logic                          w1, w2;
  logic [fip_pkg::SlotBits-1:0]  slot1, slot2;
  fip_pkg::index_t               v2;
  fip_pkg::index_t               fin;
  fip_pkg::cmd_t                 cmd;

  function automatic logic [fip_pkg::SlotBits-1:0] slot_of(
    logic [fip_pkg::CountBits-1:0] tok,
    logic [fip_pkg::FposBits-1:0]  fpos
  );
    return fip_pkg::SlotBits'(tok) * fip_pkg::SlotBits'(fip_pkg::Fields) +
           fip_pkg::SlotBits'(fpos);
  endfunction

  function automatic logic [fip_pkg::CountBits-1:0] sat_inc(logic [fip_pkg::CountBits-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // acc * 10 + d as shifts, wrapping at the index width
  function automatic fip_pkg::index_t mac10(fip_pkg::index_t a, logic [3:0] d);
    return (a << 3) + (a << 1) + fip_pkg::IndexBits'(d);
  endfunction

  function automatic fip_pkg::out_idx_t to_out(fip_pkg::index_t v);
    logic [fip_pkg::WideBits-1:0] w;
    w = fip_pkg::WideBits'(v);
    return w[fip_pkg::OutBits-1:0];
  endfunction

  assign cmd = cmd_side_i.cmd;
  assign go  = !cmd_side_i.empty && !(cmd.last && res_full_i);

  // character step
  always_comb begin
    tok_a    = tok_q;
    fpos_a   = fpos_q;
    acc_a    = acc_q;
    in_tok_a = in_tok_q;
    w1       = 1'b0;
    slot1    = slot_of(tok_q, fpos_q);
    case (cmd.cls)
      fip_pkg::CLS_BLANK: begin
        if (in_tok_q) begin
          if (fpos_q < fip_pkg::FposBits'(fip_pkg::Fields)) begin
            w1 = (tok_q < fip_pkg::CountBits'(fip_pkg::Corners));
          end
          tok_a    = sat_inc(tok_q);
          fpos_a   = '0;
          acc_a    = '0;
          in_tok_a = 1'b0;
        end
      end
      fip_pkg::CLS_DIGIT: begin
        in_tok_a = 1'b1;
        if (fpos_q < fip_pkg::FposBits'(fip_pkg::Fields)) begin
          acc_a = mac10(acc_q, cmd.digit);
        end
      end
      default: begin
        in_tok_a = 1'b1;
        if (fpos_q < fip_pkg::FposBits'(fip_pkg::Fields)) begin
          w1     = (tok_q < fip_pkg::CountBits'(fip_pkg::Corners));
          fpos_a = fpos_q + 1'b1;
        end
        acc_a = '0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < fip_pkg::StoreSize; k++) begin
      store_mid[k] = (w1 && slot1 == fip_pkg::SlotBits'(k)) ? acc_q : store_q[k];
    end
  end

  // line-end close of an open token
  always_comb begin
    w2    = 1'b0;
    v2    = acc_a;
    tok_b = tok_a;
    slot2 = slot_of(tok_a, fpos_a);
    if (in_tok_a) begin
      if (fpos_a < fip_pkg::FposBits'(fip_pkg::Fields)) begin
        w2 = (tok_a < fip_pkg::CountBits'(fip_pkg::Corners));
      end
      tok_b = sat_inc(tok_a);
    end
  end

  always_comb begin
    fin = '0;
    for (int k = 0; k < fip_pkg::StoreSize; k++) begin
      fin = (w2 && slot2 == fip_pkg::SlotBits'(k)) ? v2 : store_mid[k];
      res_push_o.res.idx[k] = to_out(fin - 1'b1);
    end
    res_push_o.res.count_error = (tok_b != fip_pkg::CountBits'(fip_pkg::Corners));
    res_push_o.push            = go && cmd.last;
  end

  assign cmd_pop_o = go;

  always_comb begin
    tok_d    = tok_q;
    fpos_d   = fpos_q;
    acc_d    = acc_q;
    in_tok_d = in_tok_q;
    store_d  = store_q;
    if (go) begin
      if (cmd.last) begin
        tok_d    = '0;
        fpos_d   = '0;
        acc_d    = '0;
        in_tok_d = 1'b0;
        store_d  = '0;
      end else begin
        tok_d    = tok_a;
        fpos_d   = fpos_a;
        acc_d    = acc_a;
        in_tok_d = in_tok_a;
        store_d  = store_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      fpos_q   <= '0;
      acc_q    <= '0;
      in_tok_q <= 1'b0;
      store_q  <= '0;
    end else begin
      tok_q    <= tok_d;
      fpos_q   <= fpos_d;
      acc_q    <= acc_d;
      in_tok_q <= in_tok_d;
      store_q  <= store_d;
    end
  end

endmodule

/* src/fip_out_queue.sv */
// result queue in front of the output ports
module fip_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fip_pkg::res_push_t res_push_i,
  output logic               res_full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output fip_pkg::result_t   head_o
);

  fip_pkg::result_t [fip_pkg::QueueDepth-1:0] slot_q;
  logic [fip_pkg::QcntBits-1:0] count_q, count_d;
  logic [fip_pkg::QptrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic                         do_push, do_pop;

  assign res_full_o = (count_q == fip_pkg::QcntBits'(fip_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = res_push_i.push && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == fip_pkg::QptrBits'(fip_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fip_pkg::QptrBits'(fip_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_push_i.res;
    end
  end

  assign head_o = slot_q[rd_ptr_q];

endmodule

/* src/face_index_line_parser.sv */
// top level of the face index line parser
// throughput: one byte item per cycle, sustained; one result item per line
// a line's result is built as its last byte is taken and is registered in the result queue
// the only stall comes from the result queue: a last byte waits while that queue is full
// reset (rst_ni low, asynchronous) empties both queues and clears the per-line state,
// so the index store reads as all zero until the first line writes it
module face_index_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        last_of_line_i,
  // result side
  input  logic        pop,
  output logic        empty,
  output logic [15:0] corner0_vertex_o,
  output logic [15:0] corner0_texture_o,
  output logic [15:0] corner0_normal_o,
  output logic [15:0] corner1_vertex_o,
  output logic [15:0] corner1_texture_o,
  output logic [15:0] corner1_normal_o,
  output logic [15:0] corner2_vertex_o,
  output logic [15:0] corner2_texture_o,
  output logic [15:0] corner2_normal_o,
  output logic        count_error_o
);

  // front to back: classified byte at the head of the command queue
  fip_pkg::cmd_side_t cmd_side;
  logic               cmd_pop;
  // back to result queue
  fip_pkg::res_push_t res_push;
  logic               res_full;
  fip_pkg::result_t   head;

  // classifies each byte (blank, digit, other) and parks it in a two-entry queue
  fip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .text_byte_i    (text_byte_i),
    .last_of_line_i (last_of_line_i),
    .cmd_pop_i      (cmd_pop),
    .cmd_side_o     (cmd_side)
  );

  // token and number tracking, index store, result build on the last byte
  fip_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_side_i (cmd_side),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push)
  );

  // finished results wait here so the byte side keeps moving
  fip_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_full_o (res_full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // store order is corner-major: vertex, texture, normal per corner
  assign corner0_vertex_o  = head.idx[0];
  assign corner0_texture_o = head.idx[1];
  assign corner0_normal_o  = head.idx[2];
  assign corner1_vertex_o  = head.idx[3];
  assign corner1_texture_o = head.idx[4];
  assign corner1_normal_o  = head.idx[5];
  assign corner2_vertex_o  = head.idx[6];
  assign corner2_texture_o = head.idx[7];
  assign corner2_normal_o  = head.idx[8];
  assign count_error_o     = head.count_error;

endmodule

/* src/fip_checker.sv */
// port-level checks of the face index line parser and their binding
`include "assert_macros.svh"

module fip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [15:0] corner0_vertex_o,
  input logic [15:0] corner0_texture_o,
  input logic [15:0] corner0_normal_o,
  input logic [15:0] corner1_vertex_o,
  input logic [15:0] corner1_texture_o,
  input logic [15:0] corner1_normal_o,
  input logic [15:0] corner2_vertex_o,
  input logic [15:0] corner2_texture_o,
  input logic [15:0] corner2_normal_o,
  input logic        count_error_o
);

  // a waiting result stays put until taken
  `ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(count_error_o) &&
    $stable(corner0_vertex_o) && $stable(corner0_texture_o) && $stable(corner0_normal_o) &&
    $stable(corner1_vertex_o) && $stable(corner1_texture_o) && $stable(corner1_normal_o) &&
    $stable(corner2_vertex_o) && $stable(corner2_texture_o) && $stable(corner2_normal_o),
    "result changed while stalled")

  // with the result queue empty the back end drains the byte queue
  `ASSERT_NEXT(a_full_drains, clk_i, rst_ni, full && empty, !full, "byte queue stuck full")

  // the byte queue only fills through a push
  `ASSERT_NOW(a_full_by_push, clk_i, rst_ni, $rose(full), $past(push), "full rose with no push")

endmodule

bind face_index_line_parser fip_checker u_fip_checker (.*);
